### design/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CoefW = 16;
  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    REG_AC1     = 3'd0,
    REG_AC2     = 3'd1,
    REG_AC3     = 3'd2,
    REG_AC4     = 3'd3,
    REG_AC5_AC6 = 3'd4,
    REG_B1      = 3'd5,
    REG_B2      = 3'd6,
    REG_MC_MD   = 3'd7
  } reg_idx_t;

  localparam logic [CoefW-1:0] RST_AC1 = 16'd408;
  localparam logic [CoefW-1:0] RST_AC2 = 16'hFFB8;
  localparam logic [CoefW-1:0] RST_AC3 = 16'hC7D1;
  localparam logic [CoefW-1:0] RST_AC4 = 16'd32741;
  localparam logic [DataW-1:0] RST_AC5_AC6 = 32'd2146785905;
  localparam logic [CoefW-1:0] RST_B1 = 16'd6190;
  localparam logic [CoefW-1:0] RST_B2 = 16'd4;
  localparam logic [DataW-1:0] RST_MC_MD = 32'd3724086068;

  localparam logic [DataW-1:0] B6_OFFSET  = 32'd4000;
  localparam logic [DataW-1:0] B4_OFFSET  = 32'd32768;
  localparam logic [DataW-1:0] B7_SCALE   = 32'd50000;
  localparam logic [DataW-1:0] P_COEF_A   = 32'd3038;
  localparam logic [DataW-1:0] P_COEF_BN  = 32'hFFFFE343;
  localparam logic [DataW-1:0] P_COEF_C   = 32'd3791;
  localparam logic [DataW-1:0] T_ROUND    = 32'd8;
  localparam logic [DataW-1:0] B_ROUND    = 32'd2;

  localparam logic [4:0] SH_TEMP = 5'd15;
  localparam logic [4:0] SH_MC   = 5'd11;
  localparam logic [4:0] SH_SQ   = 5'd12;
  localparam logic [4:0] SH_A    = 5'd11;
  localparam logic [4:0] SH_B    = 5'd13;
  localparam logic [4:0] SH_C    = 5'd16;
  localparam logic [4:0] SH_4    = 5'd2;
  localparam logic [4:0] SH_16   = 5'd4;
  localparam logic [4:0] SH_256  = 5'd8;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T0,
    S_T1,
    S_TDIV,
    S_P0,
    S_P1,
    S_P2,
    S_P3,
    S_P4,
    S_P5,
    S_P6,
    S_P7,
    S_PDIV,
    S_P8,
    S_P9,
    S_P10,
    S_P11,
    S_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

  // signed divide by 2^k, truncating toward zero
  function automatic logic [DataW-1:0] sdiv_pow2(input logic [DataW-1:0] a,
                                                 input logic [4:0] k);
    logic [DataW-1:0] bias;
    logic [DataW-1:0] sum;
    bias = a[DataW-1] ? ((32'd1 << k) - 32'd1) : 32'd0;
    sum  = a + bias;
    return DataW'($signed(sum) >>> k);
  endfunction

endpackage
`default_nettype wire

### design/bsc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bsc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] raw_reading;
  modport source (output valid, output func, output raw_reading, input ready);
  modport sink (input valid, input func, input raw_reading, output ready);
endinterface

interface bsc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] compensated;
  logic        is_pressure;
  logic        divide_fault;
  modport source (output valid, output compensated, output is_pressure,
                  output divide_fault, input ready);
  modport sink (input valid, input compensated, input is_pressure,
                input divide_fault, output ready);
endinterface
`default_nettype wire

### design/bsc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bsc_div
  import bsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DataW-1:0] rem_r, rem_nxt;
  logic [DataW-1:0] quo_r, quo_nxt;
  logic [DataW-1:0] dvs_r, dvs_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DataW:0]   shifted;
  logic [DataW+1:0] diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted  = {rem_r, quo_r[DataW-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 6'(DataW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DataW+1]) begin
        rem_nxt = diff[DataW-1:0];
        quo_nxt = {quo_r[DataW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DataW-1:0];
        quo_nxt = {quo_r[DataW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

### design/barometric_sensor_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// Pressure and temperature compensation for a barometric sensor. A temperature
// transfer (func 0) yields the temperature in 0.1 degree steps and keeps the
// intermediate B5; a pressure transfer (func 1) uses the kept B5 and returns
// pascal. One item at a time: an item's time from transfer to result is set by
// the 32-step restoring divider plus the products, taken one after another
// through the single shared 32x32 multiplier; a faulted item finishes sooner.
// A zero divisor gives 0 with divide_fault set, and B5 then stays as it was.
// The result sits in an output register, so the next item can be taken while
// it waits. Calibration registers sit on the APB port at 4*index; the user
// must write them only while idle, and the block itself does not enforce it.
module barometric_sensor_compensation
  import bsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  bsc_in_if.sink              in_chan,
  bsc_out_if.source           out_chan,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [DataW-1:0]    cfg_pwdata,
  output logic [DataW-1:0]    cfg_prdata,
  output logic                cfg_pready
);

  // calibration registers
  logic [CoefW-1:0] ac1_r, ac2_r, ac3_r, ac4_r, b1_r, b2_r;
  logic [DataW-1:0] ac56_r, mcmd_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_r  <= RST_AC1;
      ac2_r  <= RST_AC2;
      ac3_r  <= RST_AC3;
      ac4_r  <= RST_AC4;
      ac56_r <= RST_AC5_AC6;
      b1_r   <= RST_B1;
      b2_r   <= RST_B2;
      mcmd_r <= RST_MC_MD;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_AC1:     ac1_r  <= cfg_pwdata[CoefW-1:0];
        REG_AC2:     ac2_r  <= cfg_pwdata[CoefW-1:0];
        REG_AC3:     ac3_r  <= cfg_pwdata[CoefW-1:0];
        REG_AC4:     ac4_r  <= cfg_pwdata[CoefW-1:0];
        REG_AC5_AC6: ac56_r <= cfg_pwdata;
        REG_B1:      b1_r   <= cfg_pwdata[CoefW-1:0];
        REG_B2:      b2_r   <= cfg_pwdata[CoefW-1:0];
        REG_MC_MD:   mcmd_r <= cfg_pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_AC1:     cfg_prdata = {16'd0, ac1_r};
      REG_AC2:     cfg_prdata = {16'd0, ac2_r};
      REG_AC3:     cfg_prdata = {16'd0, ac3_r};
      REG_AC4:     cfg_prdata = {16'd0, ac4_r};
      REG_AC5_AC6: cfg_prdata = ac56_r;
      REG_B1:      cfg_prdata = {16'd0, b1_r};
      REG_B2:      cfg_prdata = {16'd0, b2_r};
      REG_MC_MD:   cfg_prdata = mcmd_r;
      default:     cfg_prdata = '0;
    endcase
  end

  // coefficients widened to 32 bits
  logic [DataW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ac1_r[15]}}, ac1_r};
  assign ac2 = {{16{ac2_r[15]}}, ac2_r};
  assign ac3 = {{16{ac3_r[15]}}, ac3_r};
  assign ac4 = {16'd0, ac4_r};
  assign ac5 = {16'd0, ac56_r[31:16]};
  assign ac6 = {16'd0, ac56_r[15:0]};
  assign b1  = {{16{b1_r[15]}}, b1_r};
  assign b2  = {{16{b2_r[15]}}, b2_r};
  assign mc  = {{16{mcmd_r[31]}}, mcmd_r[31:16]};
  assign md  = {{16{mcmd_r[15]}}, mcmd_r[15:0]};

  // sequencer and working registers
  state_t           state_r, state_nxt;
  logic [15:0]      raw_r, raw_nxt;
  logic             func_r, func_nxt;
  logic [DataW-1:0] x1_r, x1_nxt, sq_r, sq_nxt, b6_r, b6_nxt, b3_r, b3_nxt;
  logic [DataW-1:0] b4_r, b4_nxt, b5_r, b5_nxt, p_r, p_nxt, prod_r;
  logic [DataW-1:0] res_r, res_nxt;
  logic             fault_r, fault_nxt, neg_r, neg_nxt, dbl_r, dbl_nxt;
  logic             out_valid_r, out_valid_nxt, out_func_r, out_func_nxt;
  logic             out_fault_r, out_fault_nxt;
  logic [DataW-1:0] out_res_r, out_res_nxt;

  // shared multiplier, low word of the product
  logic [DataW-1:0] mul_a, mul_b, mul_lo;
  assign mul_lo = mul_a * mul_b;

  div_req_t div_req;
  div_rsp_t div_rsp;

  bsc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  logic             in_xfer;
  logic [DataW-1:0] den, mcs, x2, t_sum, qs;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    raw_nxt       = raw_r;
    func_nxt      = func_r;
    x1_nxt        = x1_r;
    sq_nxt        = sq_r;
    b6_nxt        = b6_r;
    b3_nxt        = b3_r;
    b4_nxt        = b4_r;
    b5_nxt        = b5_r;
    p_nxt         = p_r;
    res_nxt       = res_r;
    fault_nxt     = fault_r;
    neg_nxt       = neg_r;
    dbl_nxt       = dbl_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_res_nxt   = out_res_r;
    out_func_nxt  = out_func_r;
    out_fault_nxt = out_fault_r;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;
    den           = x1_r + md;
    mcs           = mc << SH_MC;
    x2            = '0;
    t_sum         = '0;
    qs            = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          raw_nxt   = in_chan.raw_reading;
          func_nxt  = in_chan.func;
          fault_nxt = 1'b0;
          res_nxt   = '0;
          state_nxt = in_chan.func ? S_P0 : S_T0;
        end
      end
      // temperature: x1 from the raw word
      S_T0: begin
        mul_a     = {16'd0, raw_r} - ac6;
        mul_b     = ac5;
        state_nxt = S_T1;
      end
      S_T1: begin
        x1_nxt = sdiv_pow2(prod_r, SH_TEMP);
        den    = sdiv_pow2(prod_r, SH_TEMP) + md;
        if (den == '0) begin
          fault_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          neg_nxt          = mcs[DataW-1] ^ den[DataW-1];
          div_req.start    = 1'b1;
          div_req.dividend = mcs[DataW-1] ? (32'd0 - mcs) : mcs;
          div_req.divisor  = den[DataW-1] ? (32'd0 - den) : den;
          state_nxt        = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_rsp.done) begin
          x2        = neg_r ? (32'd0 - div_rsp.quotient) : div_rsp.quotient;
          b5_nxt    = x1_r + x2;
          res_nxt   = sdiv_pow2(x1_r + x2 + T_ROUND, SH_16);
          state_nxt = S_FIN;
        end
      end
      // pressure: products of b6 and sq
      S_P0: begin
        b6_nxt    = b5_r - B6_OFFSET;
        mul_a     = b5_r - B6_OFFSET;
        mul_b     = b5_r - B6_OFFSET;
        state_nxt = S_P1;
      end
      S_P1: begin
        sq_nxt    = sdiv_pow2(prod_r, SH_SQ);
        mul_a     = b2;
        mul_b     = sdiv_pow2(prod_r, SH_SQ);
        state_nxt = S_P2;
      end
      S_P2: begin
        x1_nxt    = sdiv_pow2(prod_r, SH_A);
        mul_a     = ac2;
        mul_b     = b6_r;
        state_nxt = S_P3;
      end
      S_P3: begin
        x2        = sdiv_pow2(prod_r, SH_A);
        t_sum     = (ac1 << 2) + x1_r + x2 + B_ROUND;
        b3_nxt    = sdiv_pow2(t_sum, SH_4);
        mul_a     = ac3;
        mul_b     = b6_r;
        state_nxt = S_P4;
      end
      S_P4: begin
        x1_nxt    = sdiv_pow2(prod_r, SH_B);
        mul_a     = b1;
        mul_b     = sq_r;
        state_nxt = S_P5;
      end
      S_P5: begin
        x2        = sdiv_pow2(prod_r, SH_C);
        t_sum     = sdiv_pow2(x1_r + x2 + B_ROUND, SH_4);
        mul_a     = ac4;
        mul_b     = t_sum + B4_OFFSET;
        state_nxt = S_P6;
      end
      S_P6: begin
        b4_nxt = {15'd0, prod_r[DataW-1:15]};
        if (prod_r[DataW-1:15] == '0) begin
          fault_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          mul_a     = {16'd0, raw_r} - b3_r;
          mul_b     = B7_SCALE;
          state_nxt = S_P7;
        end
      end
      // b7 fits doubling only below half range
      S_P7: begin
        dbl_nxt          = prod_r[DataW-1];
        div_req.start    = 1'b1;
        div_req.dividend = prod_r[DataW-1] ? prod_r : (prod_r << 1);
        div_req.divisor  = b4_r;
        state_nxt        = S_PDIV;
      end
      S_PDIV: begin
        if (div_rsp.done) begin
          p_nxt     = dbl_r ? (div_rsp.quotient << 1) : div_rsp.quotient;
          state_nxt = S_P8;
        end
      end
      S_P8: begin
        qs        = sdiv_pow2(p_r, SH_256);
        mul_a     = qs;
        mul_b     = qs;
        state_nxt = S_P9;
      end
      S_P9: begin
        mul_a     = prod_r;
        mul_b     = P_COEF_A;
        state_nxt = S_P10;
      end
      S_P10: begin
        x1_nxt    = sdiv_pow2(prod_r, SH_C);
        mul_a     = P_COEF_BN;
        mul_b     = p_r;
        state_nxt = S_P11;
      end
      S_P11: begin
        x2        = sdiv_pow2(prod_r, SH_C);
        res_nxt   = p_r + sdiv_pow2(x1_r + x2 + P_COEF_C, SH_16);
        state_nxt = S_FIN;
      end
      // hand over to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_func_nxt  = func_r;
          out_fault_nxt = fault_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    raw_r       <= raw_nxt;
    func_r      <= func_nxt;
    x1_r        <= x1_nxt;
    sq_r        <= sq_nxt;
    b6_r        <= b6_nxt;
    b3_r        <= b3_nxt;
    b4_r        <= b4_nxt;
    p_r         <= p_nxt;
    prod_r      <= mul_lo;
    res_r       <= res_nxt;
    fault_r     <= fault_nxt;
    neg_r       <= neg_nxt;
    dbl_r       <= dbl_nxt;
    out_res_r   <= out_res_nxt;
    out_func_r  <= out_func_nxt;
    out_fault_r <= out_fault_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      b5_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      b5_r        <= b5_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.compensated  = out_res_r;
  assign out_chan.is_pressure  = out_func_r;
  assign out_chan.divide_fault = out_fault_r;

`ifndef SYNTHESIS
  // a faulted result always reads zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r) |-> (out_res_r == '0))
    else $error("faulted result not zero");

  // divider is never restarted while busy
  assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // b5 changes only when a temperature quotient lands
  assert property (@(posedge clk)
    (rst_n && $past(rst_n) && ($past(state_r) != S_TDIV)) |-> (b5_r == $past(b5_r)))
    else $error("b5 changed outside temperature path");

  // an accepted item leaves the idle state
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != S_IDLE))
    else $error("accepted item not started");
`endif

endmodule
`default_nettype wire

### test/barometric_sensor_compensation_tb.sv
`timescale 1ns / 1ps
module barometric_sensor_compensation_tb
  import bsc_pkg::*;
;

  // fixed values of the pressure polynomial
  localparam logic [31:0] OFS_B6   = 32'd4000;
  localparam logic [31:0] OFS_B4   = 32'd32768;
  localparam logic [31:0] MUL_B7   = 32'd50000;
  localparam logic [31:0] POLY_A   = 32'd3038;
  localparam logic [31:0] POLY_BN  = 32'hFFFFE343; // -7357
  localparam logic [31:0] POLY_C   = 32'd3791;
  localparam int          IDLE_PCT = 18;
  localparam int          SETTLE   = 60;   // a little over the slowest item

  typedef enum logic {FN_TEMP = 1'b0, FN_PRESS = 1'b1} func_t;
  typedef enum int {CAL_RESET, CAL_ZERO_DIV, CAL_MIN, CAL_MAX, CAL_RANDOM} cal_set_t;

  typedef struct {
    logic [31:0] value;
    logic        is_pressure;
    logic        fault;
  } reading_t;

  typedef struct {
    cal_set_t    cal;
    func_t       fn;
    logic [15:0] raw;
    bit          typed;     // expectation given in the row itself
    logic [31:0] value;
    logic        fault;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  bsc_in_if  in_chan();
  bsc_out_if out_chan();

  barometric_sensor_compensation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: calibration words as written and the kept b5
  logic [31:0] cal_word [8];
  logic [31:0] held_b5;
  reading_t    expected_readings [$];
  int          error_count = 0;
  bit          steady = 1'b0;   // no idling on either side while set

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s expected %h got %h", $realtime, what, want, got);
    error_count++;
  endtask

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // signed quotient, truncated toward zero; most negative / -1 wraps
  function automatic logic [31:0] trunc_div(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? 32'd0 - q : q;
  endfunction

  function automatic reading_t compensate_reading(input func_t fn, input logic [15:0] raw);
    reading_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
    ac1 = sext16(cal_word[REG_AC1][15:0]);
    ac2 = sext16(cal_word[REG_AC2][15:0]);
    ac3 = sext16(cal_word[REG_AC3][15:0]);
    ac4 = {16'd0, cal_word[REG_AC4][15:0]};
    ac5 = {16'd0, cal_word[REG_AC5_AC6][31:16]};
    ac6 = {16'd0, cal_word[REG_AC5_AC6][15:0]};
    b1  = sext16(cal_word[REG_B1][15:0]);
    b2  = sext16(cal_word[REG_B2][15:0]);
    mc  = sext16(cal_word[REG_MC_MD][31:16]);
    md  = sext16(cal_word[REG_MC_MD][15:0]);
    r.value = 32'd0;
    r.is_pressure = fn;
    r.fault = 1'b0;
    if (fn == FN_TEMP) begin
      x1  = trunc_div(({16'd0, raw} - ac6) * ac5, 32'd32768);
      den = x1 + md;
      if (den == 32'd0) begin
        r.fault = 1'b1;   // b5 left as it was
      end else begin
        x2 = trunc_div(mc * 32'd2048, den);
        b5 = x1 + x2;
        held_b5 = b5;
        r.value = trunc_div(b5 + 32'd8, 32'd16);
      end
    end else begin
      b6 = held_b5 - OFS_B6;
      sq = trunc_div(b6 * b6, 32'd4096);
      x1 = trunc_div(b2 * sq, 32'd2048);
      x2 = trunc_div(ac2 * b6, 32'd2048);
      x3 = x1 + x2;
      b3 = trunc_div(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
      x1 = trunc_div(ac3 * b6, 32'd8192);
      x2 = trunc_div(b1 * sq, 32'd65536);
      x3 = trunc_div(x1 + x2 + 32'd2, 32'd4);
      b4 = (ac4 * (x3 + OFS_B4)) / 32'd32768;   // unsigned step
      if (b4 == 32'd0) begin
        r.fault = 1'b1;
      end else begin
        b7 = ({16'd0, raw} - b3) * MUL_B7;
        if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = trunc_div(p, 32'd256);
        x1 = x1 * x1;
        x1 = trunc_div(x1 * POLY_A, 32'd65536);
        x2 = trunc_div(POLY_BN * p, 32'd65536);
        r.value = p + trunc_div(x1 + x2 + POLY_C, 32'd16);
      end
    end
    return r;
  endfunction

  // result side: random back-pressure and the scoreboard
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, out_chan.compensated);
      end else begin
        want = expected_readings.pop_front();
        if (out_chan.compensated !== want.value)
          report_mismatch("compensated", want.value, out_chan.compensated);
        if (out_chan.is_pressure !== want.is_pressure)
          report_mismatch("is_pressure", 32'(want.is_pressure),
                          32'(out_chan.is_pressure));
        if (out_chan.divide_fault !== want.fault)
          report_mismatch("divide_fault", 32'(want.fault), 32'(out_chan.divide_fault));
      end
    end
  end

  // apb write: setup then access, register taken when pready is high
  task automatic write_coef(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CfgAddrW'(4 * int'(idx));
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cal_word[idx] = (idx == REG_AC5_AC6 || idx == REG_MC_MD) ? val : {16'd0, val[15:0]};
  endtask

  task automatic wait_idle();
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_cal(input cal_set_t cs);
    logic [31:0] w [8];
    case (cs)
      CAL_RESET: begin
        w = '{32'd408, 32'hFFB8, 32'hC7D1, 32'd32741, 32'd2146785905,
              32'd6190, 32'd4, 32'd3724086068};
      end
      CAL_ZERO_DIV: begin
        // ac5 = 0 and md = 0 zero the temperature divisor, ac4 = 0 zeroes b4
        w = '{32'd408, 32'hFFB8, 32'hC7D1, 32'd0, 32'h0000_4000,
              32'd6190, 32'd4, 32'h1234_0000};
      end
      CAL_MIN: begin
        w = '{32'h8000, 32'h8000, 32'h8000, 32'h0000, 32'h0000_0000,
              32'h8000, 32'h8000, 32'h8000_8000};
      end
      CAL_MAX: begin
        w = '{32'h7FFF, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'hFFFF_FFFF,
              32'h7FFF, 32'h7FFF, 32'h7FFF_7FFF};
      end
      default: begin
        foreach (w[i]) w[i] = $urandom;
      end
    endcase
    // writes run back to back, the bus is released after the last one
    for (int i = 0; i < 8; i++) write_coef(reg_idx_t'(i), w[i]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // one input transfer; valid stays up straight into the next item when there is no gap
  task automatic send_item(input func_t fn, input logic [15:0] raw, input bit typed,
                           input logic [31:0] value, input logic fault);
    reading_t r;
    in_chan.valid       <= 1'b1;
    in_chan.func        <= fn;
    in_chan.raw_reading <= raw;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    r = compensate_reading(fn, raw);
    if (typed) begin
      r.value = value;
      r.fault = fault;
    end
    expected_readings.push_back(r);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  dir_row_t dir_rows [18] = '{
    // pressure before any temperature uses b5 = 0
    '{CAL_RESET,    FN_PRESS, 16'd23843, 1'b0, 32'd0, 1'b0},
    '{CAL_RESET,    FN_PRESS, 16'hFFFF,  1'b0, 32'd0, 1'b0},
    '{CAL_RESET,    FN_TEMP,  16'd27898, 1'b0, 32'd0, 1'b0},
    '{CAL_RESET,    FN_PRESS, 16'd23843, 1'b0, 32'd0, 1'b0},
    '{CAL_RESET,    FN_PRESS, 16'd0,     1'b0, 32'd0, 1'b0},
    '{CAL_RESET,    FN_PRESS, 16'hFFFF,  1'b0, 32'd0, 1'b0},
    '{CAL_RESET,    FN_TEMP,  16'd0,     1'b0, 32'd0, 1'b0},
    '{CAL_RESET,    FN_PRESS, 16'h8000,  1'b0, 32'd0, 1'b0},
    '{CAL_RESET,    FN_TEMP,  16'hFFFF,  1'b0, 32'd0, 1'b0},
    '{CAL_RESET,    FN_PRESS, 16'h7FFF,  1'b0, 32'd0, 1'b0},
    // zero divisors: result 0 with the fault flag, b5 kept
    '{CAL_ZERO_DIV, FN_TEMP,  16'd27898, 1'b1, 32'd0, 1'b1},
    '{CAL_ZERO_DIV, FN_TEMP,  16'hFFFF,  1'b1, 32'd0, 1'b1},
    '{CAL_ZERO_DIV, FN_PRESS, 16'd23843, 1'b1, 32'd0, 1'b1},
    '{CAL_ZERO_DIV, FN_PRESS, 16'd0,     1'b1, 32'd0, 1'b1},
    // back to normal: pressure still sees the b5 from before the faults
    '{CAL_RESET,    FN_PRESS, 16'd23843, 1'b0, 32'd0, 1'b0},
    '{CAL_MIN,      FN_TEMP,  16'hFFFF,  1'b0, 32'd0, 1'b0},
    '{CAL_MIN,      FN_PRESS, 16'hFFFF,  1'b0, 32'd0, 1'b0},
    '{CAL_MAX,      FN_PRESS, 16'd0,     1'b0, 32'd0, 1'b0}
  };

  initial begin
    cal_set_t cur;
    int       left, run;
    rst_n              <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.func        <= FN_TEMP;
    in_chan.raw_reading <= 16'd0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    cal_word = '{32'd408, 32'hFFB8, 32'hC7D1, 32'd32741, 32'd2146785905,
                 32'd6190, 32'd4, 32'd3724086068};
    held_b5 = 32'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, calibration swapped only while idle
    cur = CAL_RESET;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cal != cur) begin
        in_chan.valid <= 1'b0;
        wait_idle();
        cur = dir_rows[i].cal;
        load_cal(cur);
      end
      send_item(dir_rows[i].fn, dir_rows[i].raw, dir_rows[i].typed,
                dir_rows[i].value, dir_rows[i].fault);
    end

    // random phases: temperature then a burst of pressures, with some noise
    for (int ph = 0; ph < 8; ph++) begin
      in_chan.valid <= 1'b0;
      wait_idle();
      case (ph)
        0, 7:    load_cal(CAL_RESET);
        1:       load_cal(CAL_MIN);
        2:       load_cal(CAL_MAX);
        default: load_cal(CAL_RANDOM);
      endcase
      steady = (ph == 4);   // one long stretch without idling
      left = 225;
      while (left > 0) begin
        if ($urandom_range(99) < 80) begin
          send_item(FN_TEMP, 16'($urandom_range(20000, 40000)), 1'b0, 32'd0, 1'b0);
          left--;
          run = $urandom_range(1, 4);
          for (int k = 0; k < run && left > 0; k++, left--)
            send_item(FN_PRESS, 16'($urandom_range(15000, 45000)), 1'b0, 32'd0, 1'b0);
        end else begin
          send_item(func_t'($urandom_range(1)), 16'($urandom), 1'b0, 32'd0, 1'b0);
          left--;
        end
      end
      steady = 1'b0;
    end

    in_chan.valid <= 1'b0;
    wait_idle();
    if (error_count == 0) begin
      $display("barometric_sensor_compensation: match");
    end else begin
      $display("barometric_sensor_compensation: mismatch");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("barometric_sensor_compensation: mismatch");
    $finish;
  end

endmodule

### sim.f
design/bsc_pkg.sv
design/bsc_if.sv
design/bsc_div.sv
design/barometric_sensor_compensation.sv
test/barometric_sensor_compensation_tb.sv
